>>> src/cll_pkg.sv
// Package for the cursor linked-list engine: operation codes, status codes,
// sequencer states and the command/result beat structs. No dependencies.
package cll_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        OP_INIT        = 3'd0,
        OP_MAKE_LIST   = 3'd1,
        OP_INSERT      = 3'd2,
        OP_DELETE      = 3'd3,
        OP_FIND        = 3'd4,
        OP_DELETE_LIST = 3'd5,
        OP_READ        = 3'd6,
        OP_NONE        = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_FND  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]       operation;
        logic [IDX_W-1:0] list_head;
        logic [IDX_W-1:0] position;
        logic [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] node_index;
        logic [VAL_W-1:0] node_value;
        logic [IDX_W-1:0] next_index;
        logic [1:0]       status;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_RD_A,     // issue link read at addr_reg
        S_WT_A,     // wait for registered read
        S_FB_HEAD,  // free_body: got head link, clear head link
        S_FB_RD,    // free_body: read link of p
        S_FB_WT,
        S_FB_GIVE0, // read free head
        S_FB_GIVE1,
        S_FB_GIVE2, // write link[p]=free; link[0]=p follows in S_FB_HEAD
        S_TK_RD0,   // take_free: read link[0]
        S_TK_WT0,
        S_TK_RD1,   // read link[n]
        S_TK_WT1,
        S_TK_WR,    // write link[0]=link[n]
        S_INS_RD,   // read link[pos]
        S_INS_WT,
        S_INS_WR,
        S_WK_RD,    // walk: read link of prev
        S_WK_WT,
        S_WK_CMP,   // data of c available
        S_DL_RD,    // delete: read link[c]
        S_DL_WT,
        S_DL_WR,    // link[prev]=link[c]
        S_DL_F0,
        S_DL_F1,
        S_DL_F2,
        S_RDN,
        S_RDN_WT,
        S_DONE
    } state_t;

endpackage

>>> src/cll_ram.sv
// Generic single-port RAM with registered read, one write or read per cycle.
// No dependencies.
module cll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/cursor_linked_list_engine_core.sv
// Cursor linked-list engine: lists of nodes in link and data RAMs, node 0 heads
// the free pool. One command at a time; results cannot be stalled. The single
// link-RAM port sets the pace. Reset clears the sequencer only; RAM is undefined.
module cursor_linked_list_engine_core #(
    parameter int NODES      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cll_pkg::cmd_t cmd,
    output logic          done,
    output cll_pkg::rsp_t rsp
);
    import cll_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int SW = $clog2(NODES + 1);

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [AW-1:0]         prev_reg, prev_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic [AW-1:0]         nx_reg, nx_next;
    logic [SW-1:0]         steps_reg, steps_next;
    logic [AW:0]           init_reg, init_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  done_reg, done_next;
    logic                  mk_reg, mk_next;     // make_list: take after free_body

    logic                  l_we, d_we;
    logic [AW-1:0]         l_addr, d_addr;
    logic [IDX_W-1:0]      l_wdata, l_rdata;
    logic [VALUE_BITS-1:0] d_wdata, d_rdata;
    logic [VALUE_BITS-1:0] val;

    assign val = cmd_reg.value[VALUE_BITS-1:0];

    cll_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_link (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
    );
    cll_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODES)) u_data (
        .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
    );

    function automatic logic vnode(input logic [IDX_W-1:0] i);
        return (i != '0) && ({22'd0, i} < NODES);
    endfunction

    // Link value is a usable node pointer when nonzero and in range.
    logic l_ok;
    assign l_ok = vnode(l_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        addr_reg  <= addr_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        nx_reg    <= nx_next;
        steps_reg <= steps_next;
        init_reg  <= init_next;
        rsp_reg   <= rsp_next;
        mk_reg    <= mk_next;
    end

    // Next state and datapath registers.
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        nx_next    = nx_reg;
        steps_next = steps_reg;
        init_next  = init_reg;
        rsp_next   = rsp_reg;
        mk_next    = mk_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rsp_next   = '0;
                    steps_next = '0;
                    init_next  = '0;
                    mk_next    = 1'b0;
                    addr_next  = cmd.list_head[AW-1:0];
                    prev_next  = cmd.list_head[AW-1:0];
                    case (op_t'(cmd.operation))
                        OP_INIT:
                        begin
                            state_next = S_INIT;
                        end
                        OP_MAKE_LIST:
                        begin
                            mk_next = 1'b1;
                            state_next = vnode(cmd.list_head) ? S_RD_A : S_TK_RD0;
                        end
                        OP_INSERT:
                        begin
                            state_next = vnode(cmd.position) ? S_TK_RD0 : S_DONE;
                            if (!vnode(cmd.position))
                            begin
                                rsp_next.status = ST_NOT_FND;
                            end
                        end
                        OP_DELETE, OP_FIND, OP_DELETE_LIST:
                        begin
                            if (vnode(cmd.list_head))
                            begin
                                state_next = (op_t'(cmd.operation) == OP_DELETE_LIST)
                                    ? S_RD_A : S_WK_RD;
                            end
                            else
                            begin
                                rsp_next.status = ST_NOT_FND;
                                state_next = S_DONE;
                            end
                        end
                        OP_READ:
                        begin
                            if ({22'd0, cmd.position} < NODES)
                            begin
                                addr_next  = cmd.position[AW-1:0];
                                state_next = S_RDN;
                            end
                            else
                            begin
                                rsp_next.status = ST_NOT_FND;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                init_next = init_reg + 1'b1;
                if (init_reg == (AW+1)'(NODES - 1))
                begin
                    state_next = S_DONE;
                end
            end
            // free_body: read head link
            S_RD_A:    state_next = S_WT_A;
            S_WT_A:
            begin
                cur_next   = l_rdata[AW-1:0];
                state_next = S_FB_HEAD;
                if (!l_ok)
                begin
                    cur_next = '0;
                end
            end
            S_FB_HEAD:
            begin
                state_next = (cur_reg != '0) ? S_FB_RD : (mk_reg ? S_TK_RD0 : S_DONE);
            end
            S_FB_RD:   state_next = S_FB_WT;
            S_FB_WT:
            begin
                nx_next    = l_rdata[AW-1:0];
                if (!l_ok)
                begin
                    nx_next = '0;
                end
                state_next = S_FB_GIVE0;
            end
            S_FB_GIVE0: state_next = S_FB_GIVE1;
            S_FB_GIVE1:
            begin
                prev_next  = l_rdata[AW-1:0];  // old free head
                state_next = S_FB_GIVE2;
            end
            S_FB_GIVE2:
            begin
                // link[p] = old free head here; hold p so S_FB_HEAD points the pool at it
                steps_next = steps_reg + 1'b1;
                prev_next  = cur_reg;
                cur_next   = nx_reg;
                state_next = S_FB_HEAD;
                if (steps_reg + 1'b1 >= SW'(NODES))
                begin
                    cur_next = '0;
                end
            end
            // take_free
            S_TK_RD0:  state_next = S_TK_WT0;
            S_TK_WT0:
            begin
                cur_next   = l_rdata[AW-1:0];
                state_next = S_TK_RD1;
                if (!l_ok)
                begin
                    rsp_next.status = ST_NO_SPACE;
                    state_next = S_DONE;
                end
            end
            S_TK_RD1:  state_next = S_TK_WT1;
            S_TK_WT1:
            begin
                nx_next    = l_rdata[AW-1:0];
                state_next = S_TK_WR;
            end
            S_TK_WR:
            begin
                rsp_next.node_index = IDX_W'(cur_reg);
                if (mk_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    addr_next  = cmd_reg.position[AW-1:0];
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:  state_next = S_INS_WT;
            S_INS_WT:
            begin
                nx_next    = l_rdata[AW-1:0];
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                // make_list: link[p]=0; insert: link[p]=link[pos], then link[pos]=p
                state_next = mk_reg ? S_DONE : S_DL_F2;
            end
            // walk for find/delete: prev_reg holds the predecessor
            S_WK_RD:   state_next = S_WK_WT;
            S_WK_WT:
            begin
                cur_next   = l_rdata[AW-1:0];
                state_next = S_WK_CMP;
                if (!l_ok || steps_reg >= SW'(NODES))
                begin
                    rsp_next.status = ST_NOT_FND;
                    state_next = S_DONE;
                end
            end
            S_WK_CMP:
            begin
                if (d_rdata == val)
                begin
                    rsp_next.node_index = IDX_W'(cur_reg);
                    state_next = (op_t'(cmd_reg.operation) == OP_DELETE) ? S_DL_RD : S_DONE;
                end
                else
                begin
                    steps_next = steps_reg + 1'b1;
                    prev_next  = cur_reg;
                    state_next = S_WK_RD;
                end
            end
            S_DL_RD:   state_next = S_DL_WT;
            S_DL_WT:
            begin
                nx_next    = l_rdata[AW-1:0];
                state_next = S_DL_WR;
            end
            S_DL_WR:   state_next = S_DL_F0;
            S_DL_F0:   state_next = S_DL_F1;
            S_DL_F1:
            begin
                nx_next    = l_rdata[AW-1:0];
                state_next = S_DL_F2;
            end
            S_DL_F2:
            begin
                // delete: link[c]=old free head, then link[0]=c in DONE-bound cycle
                // insert: link[pos]=p
                state_next = (op_t'(cmd_reg.operation) == OP_DELETE) ? S_RDN_WT : S_DONE;
            end
            S_RDN:     state_next = S_RDN_WT;
            S_RDN_WT:
            begin
                if (op_t'(cmd_reg.operation) == OP_READ)
                begin
                    rsp_next.node_value = VAL_W'(d_rdata);
                    rsp_next.next_index = l_rdata;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // RAM port control per state.
    always_comb
    begin
        l_we    = 1'b0;
        d_we    = 1'b0;
        l_addr  = addr_reg;
        d_addr  = cur_reg;
        l_wdata = '0;
        d_wdata = val;
        case (state_reg)
            S_INIT:
            begin
                l_we    = 1'b1;
                l_addr  = init_reg[AW-1:0];
                l_wdata = (init_reg == (AW+1)'(NODES - 1)) ? '0 : IDX_W'(init_reg + 1'b1);
            end
            S_RD_A:     l_addr = prev_reg;
            S_FB_HEAD:
            begin
                if (steps_reg == '0 && addr_reg == prev_reg)
                begin
                    l_we   = 1'b1;   // clear header link once
                    l_addr = addr_reg;
                end
            end
            S_FB_RD:    l_addr = cur_reg;
            S_FB_GIVE0: l_addr = '0;
            S_FB_GIVE2:
            begin
                l_we    = 1'b1;
                l_addr  = cur_reg;
                l_wdata = IDX_W'(prev_reg);
            end
            S_TK_RD0:   l_addr = '0;
            S_TK_RD1:   l_addr = cur_reg;
            S_TK_WR:
            begin
                l_we    = 1'b1;
                l_addr  = '0;
                l_wdata = IDX_W'(nx_reg);
            end
            S_INS_RD:   l_addr = addr_reg;
            S_INS_WR:
            begin
                l_we    = 1'b1;
                l_addr  = cur_reg;
                l_wdata = mk_reg ? '0 : IDX_W'(nx_reg);
                d_we    = !mk_reg;
            end
            S_WK_RD:    l_addr = prev_reg;
            S_WK_WT:    d_addr = l_rdata[AW-1:0];
            S_DL_RD:    l_addr = cur_reg;
            S_DL_WR:
            begin
                l_we    = 1'b1;
                l_addr  = prev_reg;
                l_wdata = IDX_W'(nx_reg);
            end
            S_DL_F0:    l_addr = '0;
            S_DL_F2:
            begin
                l_we = 1'b1;
                if (op_t'(cmd_reg.operation) == OP_DELETE)
                begin
                    l_addr  = cur_reg;
                    l_wdata = IDX_W'(nx_reg);
                end
                else
                begin
                    l_addr  = cmd_reg.position[AW-1:0];
                    l_wdata = IDX_W'(cur_reg);
                end
            end
            S_RDN:
            begin
                l_addr = addr_reg;
                d_addr = addr_reg;
            end
            S_RDN_WT:
            begin
                if (op_t'(cmd_reg.operation) == OP_DELETE)
                begin
                    l_we    = 1'b1;  // free head now points at the deleted node
                    l_addr  = '0;
                    l_wdata = IDX_W'(cur_reg);
                end
            end
            S_DONE:
            begin
                if (state_reg == S_DONE && op_t'(cmd_reg.operation) == OP_DELETE_LIST)
                begin
                    l_we = 1'b0;
                end
            end
            default:    l_we = 1'b0;
        endcase
        // free_body: after linking p to the old head, point the pool at p
        if (state_reg == S_FB_HEAD && steps_reg != '0)
        begin
            l_we    = 1'b1;
            l_addr  = '0;
            l_wdata = IDX_W'(prev_reg);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result beat lasted more than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE) else $error("result beat while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted command did not raise busy");
`endif

endmodule

>>> tb/cll_checker.sv
// Checker for the cursor linked-list engine: watches command and result beats,
// predicts each result from its own copy of the node memory. Depends on cll_pkg.
`timescale 1ns / 1ps
module cll_checker #(
    parameter int NODES = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  cll_pkg::cmd_t  cmd,
    input  logic           done,
    input  cll_pkg::rsp_t  rsp,
    output int             fails,
    output int             pending
);
    import cll_pkg::*;

    bit [IDX_W-1:0] link_mem [NODES];
    bit [VAL_W-1:0] data_mem [NODES];
    rsp_t           expected_rsps [$];

    function automatic bit is_node(bit [IDX_W-1:0] i);
        return i != 0 && i < NODES;
    endfunction

    function automatic bit [IDX_W-1:0] pop_free();
        bit [IDX_W-1:0] n;
        n = link_mem[0];
        if (is_node(n))
            link_mem[0] = link_mem[n];
        else
            n = 0;
        return n;
    endfunction

    function automatic void push_free(bit [IDX_W-1:0] n);
        link_mem[n] = link_mem[0];
        link_mem[0] = n;
    endfunction

    function automatic void release_body(bit [IDX_W-1:0] head);
        bit [IDX_W-1:0] p;
        bit [IDX_W-1:0] nx;
        int             steps;
        p = link_mem[head];
        link_mem[head] = 0;
        steps = 0;
        while (is_node(p) && steps < NODES)
        begin
            nx = link_mem[p];
            push_free(p);
            p = nx;
            steps++;
        end
    endfunction

    function automatic rsp_t list_result(cmd_t c);
        rsp_t           r;
        bit [IDX_W-1:0] p;
        bit [IDX_W-1:0] prev;
        bit             hit;
        int             steps;
        r = '0;
        case (op_t'(c.operation))
            OP_INIT:
                for (int i = 0; i < NODES; i++)
                    link_mem[i] = (i + 1 < NODES) ? IDX_W'(i + 1) : '0;
            OP_MAKE_LIST:
            begin
                if (is_node(c.list_head))
                    release_body(c.list_head);
                p = pop_free();
                if (p == 0)
                    r.status = ST_NO_SPACE;
                else
                begin
                    link_mem[p] = 0;
                    r.node_index = p;
                end
            end
            OP_INSERT:
            begin
                if (!is_node(c.position))
                    r.status = ST_NOT_FND;
                else
                begin
                    p = pop_free();
                    if (p == 0)
                        r.status = ST_NO_SPACE;
                    else
                    begin
                        data_mem[p] = c.value;
                        link_mem[p] = link_mem[c.position];
                        link_mem[c.position] = p;
                        r.node_index = p;
                    end
                end
            end
            OP_DELETE:
            begin
                if (!is_node(c.list_head))
                    r.status = ST_NOT_FND;
                else
                begin
                    prev = c.list_head;
                    hit = 0;
                    for (steps = 0; steps < NODES; steps++)
                    begin
                        p = link_mem[prev];
                        if (!is_node(p))
                            break;
                        if (data_mem[p] == c.value)
                        begin
                            hit = 1;
                            break;
                        end
                        prev = p;
                    end
                    if (hit)
                    begin
                        link_mem[prev] = link_mem[p];
                        push_free(p);
                        r.node_index = p;
                    end
                    else
                        r.status = ST_NOT_FND;
                end
            end
            OP_FIND:
            begin
                if (!is_node(c.list_head))
                    r.status = ST_NOT_FND;
                else
                begin
                    p = link_mem[c.list_head];
                    steps = 0;
                    while (is_node(p) && steps < NODES)
                    begin
                        if (data_mem[p] == c.value)
                        begin
                            r.node_index = p;
                            break;
                        end
                        p = link_mem[p];
                        steps++;
                    end
                    if (r.node_index == 0)
                        r.status = ST_NOT_FND;
                end
            end
            OP_DELETE_LIST:
            begin
                if (!is_node(c.list_head))
                    r.status = ST_NOT_FND;
                else
                    release_body(c.list_head);
            end
            OP_READ:
            begin
                if (c.position >= NODES)
                    r.status = ST_NOT_FND;
                else
                begin
                    r.node_value = data_mem[c.position];
                    r.next_index = link_mem[c.position];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign pending = expected_rsps.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n)
            fails <= 0;
        else
        begin
            if (start && !busy)
                expected_rsps.push_back(list_result(cmd));
            if (done)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fails <= fails + 1;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (rsp != e)
                    begin
                        if (rsp.node_index != e.node_index)
                            $error("node_index: expected %0d, got %0d",
                                   e.node_index, rsp.node_index);
                        if (rsp.node_value != e.node_value)
                            $error("node_value: expected %h, got %h",
                                   e.node_value, rsp.node_value);
                        if (rsp.next_index != e.next_index)
                            $error("next_index: expected %0d, got %0d",
                                   e.next_index, rsp.next_index);
                        if (rsp.status != e.status)
                            $error("status: expected %0d, got %0d",
                                   e.status, rsp.status);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// Top of the linked-list engine testbench: clock, reset, command stimulus and
// verdict. Depends on cll_pkg, cursor_linked_list_engine_core and cll_checker.
`timescale 1ns / 1ps
module tb_top;
    import cll_pkg::*;

    localparam int NODES = 1024;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    cmd_t  cmd;
    logic  done;
    rsp_t  rsp;
    int    fails;
    int    pending;
    int    idle_pct;

    // Shadow of list membership, used only to steer stimulus so that no walk
    // or read ever touches a node whose data was never written.
    bit              is_header [NODES];
    bit [IDX_W-1:0]  owner     [NODES];   // header of the list a node sits in
    bit              written   [NODES];
    bit [VAL_W-1:0]  stored    [NODES];
    bit [IDX_W-1:0]  headers   [$];

    cursor_linked_list_engine_core #(.NODES(NODES), .VALUE_BITS(VAL_W)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    cll_checker #(.NODES(NODES)) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .rsp     (rsp),
        .fails   (fails),
        .pending (pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Send one command beat and hold until its result beat shows up. Drive on
    // the falling edge; busy only moves on rising edges, so it is stable here.
    task automatic send_cmd(op_t op, bit [IDX_W-1:0] head, bit [IDX_W-1:0] pos,
                            bit [VAL_W-1:0] val, output rsp_t r);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        start = 1;
        cmd = '{operation: op, list_head: head, position: pos, value: val};
        @(negedge clk);
        start = 0;
        while (!done)
            @(negedge clk);
        r = rsp;
    endtask

    function automatic void drop_body(bit [IDX_W-1:0] h);
        for (int i = 0; i < NODES; i++)
            if (owner[i] == h)
                owner[i] = 0;
    endfunction

    // Issue one beat and update the shadow from its result.
    task automatic run_op(op_t op, bit [IDX_W-1:0] head, bit [IDX_W-1:0] pos,
                          bit [VAL_W-1:0] val, output rsp_t r);
        send_cmd(op, head, pos, val, r);
        case (op)
            OP_INIT:
            begin
                // every node goes back to the pool; data stays put
                foreach (owner[i])
                begin
                    owner[i] = 0;
                    is_header[i] = 0;
                end
                headers.delete();
            end
            OP_MAKE_LIST:
            begin
                if (head != 0)
                    drop_body(head);
                if (r.status == ST_OK)
                begin
                    is_header[r.node_index] = 1;
                    headers.push_back(r.node_index);
                end
            end
            OP_INSERT:
                if (r.status == ST_OK)
                begin
                    owner[r.node_index] = is_header[pos] ? pos : owner[pos];
                    written[r.node_index] = 1;
                    stored[r.node_index] = val;
                end
            OP_DELETE:
                if (r.status == ST_OK)
                    owner[r.node_index] = 0;
            OP_DELETE_LIST:
                if (head != 0)
                    drop_body(head);
            default: ;
        endcase
    endtask

    function automatic int body_size(bit [IDX_W-1:0] h, output bit [IDX_W-1:0] pick);
        int n;
        n = 0;
        pick = h;
        for (int i = 0; i < NODES; i++)
            if (owner[i] == h && !is_header[i])
            begin
                n++;
                if ($urandom_range(n - 1) == 0)
                    pick = IDX_W'(i);
            end
        return n;
    endfunction

    function automatic bit [VAL_W-1:0] rand_value();
        case ($urandom_range(3))
            0:       return $urandom_range(7);
            1:       return {VAL_W{1'b1}};
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [IDX_W-1:0] rand_idx();
        return IDX_W'($urandom);
    endfunction

    // One random beat, steered toward well-formed list traffic.
    task automatic random_op();
        rsp_t            r;
        bit [IDX_W-1:0]  h;
        bit [IDX_W-1:0]  m;
        bit [IDX_W-1:0]  rd [$];
        int              n;
        int              sel;
        if (headers.size() == 0)
        begin
            run_op(OP_MAKE_LIST, 0, rand_idx(), $urandom, r);
            return;
        end
        h = headers[$urandom_range(headers.size() - 1)];
        n = body_size(h, m);
        sel = $urandom_range(99);
        if (sel < 32 && n < 40)
            run_op(OP_INSERT, rand_idx(), m, rand_value(), r);
        else if (sel < 50)
            run_op(OP_FIND, h, rand_idx(), ($urandom_range(3) != 0 && m != h) ?
                   stored[m] : rand_value(), r);
        else if (sel < 68)
            run_op(OP_DELETE, h, rand_idx(), ($urandom_range(3) != 0 && m != h) ?
                   stored[m] : rand_value(), r);
        else if (sel < 75)
            run_op(OP_MAKE_LIST, $urandom_range(1) ? h : '0, rand_idx(), $urandom, r);
        else if (sel < 80)
            run_op(OP_DELETE_LIST, h, rand_idx(), $urandom, r);
        else if (sel < 90)
        begin
            for (int i = 1; i < NODES; i++)
                if (written[i])
                    rd.push_back(IDX_W'(i));
            if (rd.size() != 0)
                run_op(OP_READ, rand_idx(), rd[$urandom_range(rd.size() - 1)], $urandom, r);
            else
                run_op(OP_NONE, rand_idx(), rand_idx(), $urandom, r);
        end
        else if (sel < 96)
        begin
            // bad index: head or position of zero, or an unused operation code
            case ($urandom_range(4))
                0: run_op(OP_INSERT, rand_idx(), 0, $urandom, r);
                1: run_op(OP_FIND, 0, rand_idx(), $urandom, r);
                2: run_op(OP_DELETE, 0, rand_idx(), $urandom, r);
                3: run_op(OP_DELETE_LIST, 0, rand_idx(), $urandom, r);
                default: run_op(OP_NONE, rand_idx(), rand_idx(), $urandom, r);
            endcase
        end
        else if (sel < 99)
            run_op(OP_NONE, rand_idx(), rand_idx(), $urandom, r);
        else
            run_op(OP_INIT, rand_idx(), rand_idx(), $urandom, r);
    endtask

    initial
    begin
        rsp_t            r;
        bit [IDX_W-1:0]  la;
        bit [IDX_W-1:0]  lb;
        bit [IDX_W-1:0]  n1;
        rst_n = 0;
        start = 0;
        cmd = '0;
        idle_pct = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: every operation, field extremes, bad indexes, unused code.
        run_op(OP_INIT, 0, 0, 0, r);
        run_op(OP_MAKE_LIST, 0, 0, 0, r);
        la = r.node_index;
        run_op(OP_INSERT, 0, la, 0, r);
        n1 = r.node_index;
        run_op(OP_INSERT, {IDX_W{1'b1}}, la, {VAL_W{1'b1}}, r);
        run_op(OP_INSERT, 0, n1, 32'h5A5A_A5A5, r);
        run_op(OP_INSERT, 0, 0, 1, r);
        run_op(OP_FIND, la, 0, {VAL_W{1'b1}}, r);
        run_op(OP_FIND, la, 0, 32'h1234_5678, r);
        run_op(OP_FIND, 0, 0, 0, r);
        run_op(OP_READ, 0, n1, 0, r);
        run_op(OP_DELETE, la, 0, 0, r);
        run_op(OP_DELETE, la, 0, 32'h1234_5678, r);
        run_op(OP_DELETE, 0, 0, 0, r);
        run_op(OP_READ, 0, n1, 0, r);
        run_op(OP_MAKE_LIST, 0, 0, 0, r);
        lb = r.node_index;
        run_op(OP_INSERT, 0, lb, 7, r);
        run_op(OP_MAKE_LIST, la, 0, 0, r);
        run_op(OP_DELETE_LIST, lb, 0, 0, r);
        run_op(OP_DELETE_LIST, 0, 0, 0, r);
        run_op(OP_NONE, {IDX_W{1'b1}}, {IDX_W{1'b1}}, {VAL_W{1'b1}}, r);

        // Drain the pool to hit out of space on both allocating operations.
        do
            run_op(OP_MAKE_LIST, 0, 0, 0, r);
        while (r.status == ST_OK);
        run_op(OP_INSERT, 0, headers[$], $urandom, r);
        run_op(OP_MAKE_LIST, 0, 0, 0, r);
        run_op(OP_INIT, 0, 0, 0, r);

        // Random traffic in three idle regimes.
        idle_pct = 14;
        repeat (170) random_op();
        idle_pct = 50;
        repeat (165) random_op();
        // Hold off until nothing is outstanding, then run back to back.
        while (pending != 0)
            @(negedge clk);
        idle_pct = 0;
        repeat (170) random_op();

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fails == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
src/cll_pkg.sv
src/cll_ram.sv
src/cursor_linked_list_engine_core.sv
tb/cll_checker.sv
tb/tb_top.sv
